@@ src/cksf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cksf_pkg
// Shared types and constants of the cross kernel sharpen filter.
// ----------------------------------------------------------------------------
package cksf_pkg;

    localparam int CHAN_W     = 8;
    localparam int NUM_CHAN   = 3;
    localparam int DIM_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int ACC_W      = 18;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        pixel_t upper;
        pixel_t middle;
    } row_pair_t;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_WEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 2'd2;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam logic [CHAN_W-1:0] RST_CENTER_WEIGHT = 8'd5;
    localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH   = 12'd640;
    localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT  = 12'd480;
    localparam logic [DIM_W-1:0]  MIN_DIM           = 12'd3;

    localparam logic signed [ACC_W-1:0] ACC_PIX_MAX = 18'sd255;
    localparam logic [CHAN_W-1:0]       PIX_MAX     = 8'd255;

endpackage

@@ src/cksf_sharpen.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cksf_sharpen
// Five-point cross kernel on one BGR pixel, clamped to 0..255 per channel.
// ----------------------------------------------------------------------------
module cksf_sharpen
    import cksf_pkg::*;
(
    input  logic signed [CHAN_W-1:0] weight,
    input  pixel_t                   center,
    input  pixel_t                   up,
    input  pixel_t                   down,
    input  pixel_t                   left,
    input  pixel_t                   right,
    output pixel_t                   result
);

    logic [NUM_CHAN*CHAN_W-1:0] c_bits;
    logic [NUM_CHAN*CHAN_W-1:0] u_bits;
    logic [NUM_CHAN*CHAN_W-1:0] d_bits;
    logic [NUM_CHAN*CHAN_W-1:0] l_bits;
    logic [NUM_CHAN*CHAN_W-1:0] r_bits;
    logic [NUM_CHAN*CHAN_W-1:0] res_bits;

    assign c_bits = center;
    assign u_bits = up;
    assign d_bits = down;
    assign l_bits = left;
    assign r_bits = right;

    genvar ch;
    for (ch = 0; ch < NUM_CHAN; ch++)
    begin : g_chan
        logic signed [2*CHAN_W:0]  prod;
        logic signed [ACC_W-1:0]   acc;
        logic        [CHAN_W-1:0]  clamp_v;

        assign prod = weight * $signed({1'b0, c_bits[ch*CHAN_W +: CHAN_W]});
        assign acc  = ACC_W'(prod)
                    - $signed(ACC_W'(u_bits[ch*CHAN_W +: CHAN_W]))
                    - $signed(ACC_W'(d_bits[ch*CHAN_W +: CHAN_W]))
                    - $signed(ACC_W'(l_bits[ch*CHAN_W +: CHAN_W]))
                    - $signed(ACC_W'(r_bits[ch*CHAN_W +: CHAN_W]));

        always_comb
        begin
            if (acc[ACC_W-1])
            begin
                clamp_v = '0;
            end
            else if (acc > ACC_PIX_MAX)
            begin
                clamp_v = PIX_MAX;
            end
            else
            begin
                clamp_v = acc[CHAN_W-1:0];
            end
        end

        assign res_bits[ch*CHAN_W +: CHAN_W] = clamp_v;
    end

    assign result = res_bits;

endmodule

@@ src/cksf_line_buf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cksf_line_buf
// Upper and middle row stores in one RAM, registered read, write forwarding.
// ----------------------------------------------------------------------------
module cksf_line_buf
    import cksf_pkg::*;
#(
    parameter int DEPTH = 2048
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  row_pair_t                wr_data,
    output row_pair_t                rd_data
);

    row_pair_t ram_reg [DEPTH];
    row_pair_t q_reg;
    row_pair_t byp_data_reg;
    logic      byp_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ram_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg        <= ram_reg[rd_addr];
            byp_data_reg <= wr_data;
        end
    end

    // read of an address written at the same edge returns the new data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_hit_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            byp_hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = byp_hit_reg ? byp_data_reg : q_reg;

endmodule

@@ src/cross_kernel_sharpen_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cross_kernel_sharpen_filter
// Five-point cross sharpen on a raster BGR stream with two row stores.
//
//   Channel  Handshake               Payload
//   in       in_valid / in_ready     command, blue_in, green_in, red_in
//   out      out_valid / out_ready   blue_out, green_out, red_out, frame_end
//   cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One transaction per clock in both directions unless back-pressure stalls the kernel
// stage; a result enters the output register when the kernel stage that holds the
// transaction causing it moves on. The path is counters, row store read, one kernel
// stage, output register. No clearing pass after reset: row stores hold nothing of
// value until written. With out_ready low the output and kernel stages hold and in_ready drops
// only while the kernel stage holds a transaction that makes a result.
// ----------------------------------------------------------------------------
module cross_kernel_sharpen_filter
    import cksf_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  command,
    input  logic [CHAN_W-1:0]     blue_in,
    input  logic [CHAN_W-1:0]     green_in,
    input  logic [CHAN_W-1:0]     red_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [CHAN_W-1:0]     blue_out,
    output logic [CHAN_W-1:0]     green_out,
    output logic [CHAN_W-1:0]     red_out,
    output logic                  frame_end,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WID_W  = $clog2(MAX_WIDTH + 1);
    localparam int PEND_W = $clog2(MAX_WIDTH + 2);

    // configuration
    logic signed [CHAN_W-1:0] center_weight_reg;
    logic [DIM_W-1:0]         frame_width_reg;
    logic [DIM_W-1:0]         frame_height_reg;
    logic                     cfg_wr;
    logic                     geom_wr;

    // position counters
    logic [COL_W-1:0]  col_reg, col_next;
    logic [DIM_W-1:0]  row_reg, row_next;
    logic [PEND_W-1:0] pend_reg, pend_next;

    logic [WID_W-1:0]  eff_w;
    logic [DIM_W-1:0]  eff_h;
    logic [PEND_W-1:0] w_plus1;
    logic [PEND_W-1:0] pend_base;
    logic              at_origin;
    logic              pix_emit;
    logic              col_wrap;
    logic [DIM_W-1:0]  orow;
    logic [WID_W-1:0]  ocol;
    logic              interior;
    logic              pix_end;
    logic              flush_ok;
    logic              flush_upper;
    logic              flush_end;
    logic [COL_W-1:0]  flush_addr;
    logic              is_flush;
    logic              in_accept;
    logic              s1_load;
    logic [COL_W-1:0]  rd_addr;

    // kernel stage
    logic             s1_valid_reg;
    logic             s1_flush_reg;
    logic             s1_emit_reg;
    logic             s1_interior_reg;
    logic             s1_end_reg;
    logic             s1_upper_reg;
    logic [COL_W-1:0] s1_col_reg;
    pixel_t           s1_px_reg;
    logic             s1_go;

    row_pair_t lb_wr_data;
    row_pair_t lb_rd_data;
    pixel_t    old_mid;
    pixel_t    old_up;
    pixel_t    sharp_px;
    pixel_t    s1_result;

    // window: two previous middle-row pixels, pixel above, previous input
    pixel_t win_a_reg;
    pixel_t win_b_reg;
    pixel_t up_prev_reg;
    pixel_t px_prev_reg;

    // output register
    logic   out_valid_reg;
    pixel_t out_px_reg;
    logic   out_end_reg;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign geom_wr   = cfg_wr && (cfg_index == CFG_FRAME_WIDTH
                                  || cfg_index == CFG_FRAME_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_weight_reg <= RST_CENTER_WEIGHT;
            frame_width_reg   <= RST_FRAME_WIDTH;
            frame_height_reg  <= RST_FRAME_HEIGHT;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                CFG_CENTER_WEIGHT: center_weight_reg <= cfg_data[CHAN_W-1:0];
                CFG_FRAME_WIDTH:   frame_width_reg   <= cfg_data[DIM_W-1:0];
                CFG_FRAME_HEIGHT:  frame_height_reg  <= cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // effective geometry
    always_comb
    begin
        if (frame_width_reg < MIN_DIM)
        begin
            eff_w = WID_W'(MIN_DIM);
        end
        else if (32'(frame_width_reg) > 32'(MAX_WIDTH))
        begin
            eff_w = WID_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = WID_W'(frame_width_reg);
        end
    end

    assign eff_h   = (frame_height_reg < MIN_DIM) ? MIN_DIM : frame_height_reg;
    assign w_plus1 = PEND_W'(eff_w) + PEND_W'(1);

    // decisions for the incoming transaction
    assign at_origin = (col_reg == '0) && (row_reg == '0);
    assign pend_base = at_origin ? '0 : pend_reg;
    assign pix_emit  = (pend_base == w_plus1);
    assign col_wrap  = (WID_W'(col_reg) + WID_W'(1)) == eff_w;

    always_comb
    begin
        if (col_reg != '0)
        begin
            orow = row_reg - DIM_W'(1);
            ocol = WID_W'(col_reg) - WID_W'(1);
        end
        else
        begin
            orow = row_reg - DIM_W'(2);
            ocol = eff_w - WID_W'(1);
        end
    end

    assign interior = (orow >= DIM_W'(1)) && (orow <= eff_h - DIM_W'(2))
                   && (ocol >= WID_W'(1)) && (ocol <= eff_w - WID_W'(2));
    assign pix_end  = (orow == eff_h - DIM_W'(1)) && (ocol == eff_w - WID_W'(1));

    // drain order after the last pixel: end of the second-last row, then last row
    assign flush_ok    = at_origin && (pend_reg != '0);
    assign flush_upper = (pend_reg == w_plus1);
    assign flush_end   = (pend_reg == PEND_W'(1));
    assign flush_addr  = flush_upper ? COL_W'(eff_w - WID_W'(1))
                                     : COL_W'(eff_w - WID_W'(pend_reg));

    assign is_flush  = (command == CMD_FLUSH);
    assign in_accept = in_valid && in_ready;
    assign s1_load   = in_accept && (!is_flush || flush_ok);
    assign rd_addr   = is_flush ? flush_addr : col_reg;

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        pend_next = pend_reg;
        if (geom_wr)
        begin
            col_next  = '0;
            row_next  = '0;
            pend_next = '0;
        end
        else if (in_accept)
        begin
            if (is_flush)
            begin
                if (flush_ok)
                begin
                    pend_next = pend_reg - PEND_W'(1);
                end
            end
            else
            begin
                pend_next = pix_emit ? pend_base : pend_base + PEND_W'(1);
                if (col_wrap)
                begin
                    col_next = '0;
                    row_next = (row_reg == eff_h - DIM_W'(1)) ? '0
                                                              : row_reg + DIM_W'(1);
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            pend_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            pend_reg <= pend_next;
        end
    end

    // kernel stage
    assign s1_go    = s1_valid_reg && (!s1_emit_reg || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_flush_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
        end
        else if (s1_load)
        begin
            s1_valid_reg <= 1'b1;
            s1_flush_reg <= is_flush;
            s1_emit_reg  <= is_flush || pix_emit;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_interior_reg <= interior;
            s1_end_reg      <= is_flush ? flush_end : pix_end;
            s1_upper_reg    <= flush_upper;
            s1_col_reg      <= col_reg;
            s1_px_reg       <= '{red: red_in, green: green_in, blue: blue_in};
        end
    end

    assign lb_wr_data = '{upper: old_mid, middle: s1_px_reg};

    cksf_line_buf #(
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (s1_load),
        .rd_addr (rd_addr),
        .wr_en   (s1_valid_reg && !s1_flush_reg),
        .wr_addr (s1_col_reg),
        .wr_data (lb_wr_data),
        .rd_data (lb_rd_data)
    );

    assign old_mid = lb_rd_data.middle;
    assign old_up  = lb_rd_data.upper;

    cksf_sharpen u_sharpen (
        .weight (center_weight_reg),
        .center (win_b_reg),
        .up     (up_prev_reg),
        .down   (px_prev_reg),
        .left   (win_a_reg),
        .right  (old_mid),
        .result (sharp_px)
    );

    always_comb
    begin
        if (s1_flush_reg)
        begin
            s1_result = s1_upper_reg ? old_up : old_mid;
        end
        else
        begin
            s1_result = s1_interior_reg ? sharp_px : win_b_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_a_reg   <= '0;
            win_b_reg   <= '0;
            up_prev_reg <= '0;
            px_prev_reg <= '0;
        end
        else if (geom_wr)
        begin
            win_a_reg   <= '0;
            win_b_reg   <= '0;
            up_prev_reg <= '0;
            px_prev_reg <= '0;
        end
        else if (s1_go && !s1_flush_reg)
        begin
            win_a_reg   <= win_b_reg;
            win_b_reg   <= old_mid;
            up_prev_reg <= old_up;
            px_prev_reg <= s1_px_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go && s1_emit_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_emit_reg)
        begin
            out_px_reg  <= s1_result;
            out_end_reg <= s1_end_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign blue_out  = out_px_reg.blue;
    assign green_out = out_px_reg.green;
    assign red_out   = out_px_reg.red;
    assign frame_end = out_end_reg;

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= w_plus1)
        else $error("pending count beyond one row plus one pixel");

    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        WID_W'(col_reg) < eff_w)
        else $error("column count outside frame width");

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg < eff_h)
        else $error("row count outside frame height");

    a_flush_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && is_flush && flush_ok
        |=> s1_valid_reg && s1_emit_reg && s1_flush_reg)
        else $error("accepted drain transaction did not reach kernel stage");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for cross_kernel_sharpen_filter. A clocked driver feeds
// pixel and flush transactions from a queue that the stimulus block fills; a
// clocked monitor mirrors the filter (row stores, window, counters, clamped
// cross kernel) and compares every result with the oldest predicted pixel.
// Covers reset geometry, 3x3 frames with extreme weights, a wide frame under
// a long receiver hold, a tall narrow frame, out-of-range geometry and random
// frames, partial drains, broken frames and stray flushes, with random
// back-pressure.
// ----------------------------------------------------------------------------
module testbench;
    import cksf_pkg::*;

    localparam int MAX_W          = 2048;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 400;
    localparam int QUIET_CYCLES   = 10;
    localparam int RANDOM_ITEMS   = 150;
    localparam int REPORT_CAP     = 50;
    localparam int WIDE_COLS      = 20;
    localparam int TALL_ROWS      = 60;

    typedef enum int {FILL_RANDOM, FILL_EXTREME, FILL_WHITE, FILL_BLACK} fill_t;

    typedef struct packed {
        logic   cmd;
        pixel_t px;
    } stream_item_t;

    typedef struct packed {
        pixel_t px;
        logic   frame_end;
    } out_pixel_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  command = CMD_PIXEL;
    logic [CHAN_W-1:0]     blue_in = '0;
    logic [CHAN_W-1:0]     green_in = '0;
    logic [CHAN_W-1:0]     red_in = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [CHAN_W-1:0]     blue_out;
    logic [CHAN_W-1:0]     green_out;
    logic [CHAN_W-1:0]     red_out;
    logic                  frame_end;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_CENTER_WEIGHT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // stimulus to driver
    stream_item_t video_items[$];
    stream_item_t next_item;
    logic         steady = 1'b0;
    int           stall_asked = 0;
    int           stall_served = 0;
    int           hold_left = 0;
    int           idle_cycles = 0;

    // filter mirror
    logic signed [CHAN_W-1:0] weight_reg = RST_CENTER_WEIGHT;
    logic [DIM_W-1:0]         width_reg = RST_FRAME_WIDTH;
    logic [DIM_W-1:0]         height_reg = RST_FRAME_HEIGHT;
    pixel_t                   upper_row [0:MAX_W-1];
    pixel_t                   middle_row [0:MAX_W-1];
    pixel_t                   win_left = '0;
    pixel_t                   win_centre = '0;
    pixel_t                   win_right = '0;
    pixel_t                   win_up = '0;
    pixel_t                   win_down = '0;
    int                       col_pos = 0;
    int                       row_pos = 0;
    int                       pend_cnt = 0;
    out_pixel_t               expected_pixels[$];
    out_pixel_t               want;
    stream_item_t             seen_item;

    int mismatches = 0;
    int pixels_in = 0;
    int flushes_in = 0;
    int results_checked = 0;
    int reg_writes = 0;

    cross_kernel_sharpen_filter #(
        .MAX_WIDTH (MAX_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .blue_in   (blue_in),
        .green_in  (green_in),
        .red_in    (red_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .blue_out  (blue_out),
        .green_out (green_out),
        .red_out   (red_out),
        .frame_end (frame_end),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int eff_width(input logic [DIM_W-1:0] raw);
        if (raw < MIN_DIM)
            return int'(MIN_DIM);
        if (raw > MAX_W)
            return MAX_W;
        return int'(raw);
    endfunction

    function automatic int eff_height(input logic [DIM_W-1:0] raw);
        return (raw < MIN_DIM) ? int'(MIN_DIM) : int'(raw);
    endfunction

    function automatic logic [CHAN_W-1:0] cross_chan(input int k, input logic [CHAN_W-1:0] c,
            input logic [CHAN_W-1:0] u, input logic [CHAN_W-1:0] d,
            input logic [CHAN_W-1:0] l, input logic [CHAN_W-1:0] r);
        int v;
        v = k * int'(c) - int'(u) - int'(d) - int'(l) - int'(r);
        if (v < 0)
            return '0;
        if (v > int'(PIX_MAX))
            return PIX_MAX;
        return v[CHAN_W-1:0];
    endfunction

    function automatic pixel_t sharpen_pixel(input pixel_t c, input pixel_t u, input pixel_t d,
            input pixel_t l, input pixel_t r);
        pixel_t res;
        int     k;
        k = int'(weight_reg);
        res.red   = cross_chan(k, c.red, u.red, d.red, l.red, r.red);
        res.green = cross_chan(k, c.green, u.green, d.green, l.green, r.green);
        res.blue  = cross_chan(k, c.blue, u.blue, d.blue, l.blue, r.blue);
        return res;
    endfunction

    task automatic restart_frame();
        col_pos = 0;
        row_pos = 0;
        pend_cnt = 0;
        win_left = '0;
        win_centre = '0;
        win_right = '0;
        win_up = '0;
        win_down = '0;
    endtask

    task automatic apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
            input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_CENTER_WEIGHT: weight_reg = data[CHAN_W-1:0];
            CFG_FRAME_WIDTH:
            begin
                width_reg = data;
                restart_frame();
            end
            CFG_FRAME_HEIGHT:
            begin
                height_reg = data;
                restart_frame();
            end
            default: ;
        endcase
    endtask

    task automatic predict_filter_out(input stream_item_t it);
        int         w;
        int         h;
        int         q;
        int         qr;
        int         qc;
        int         orow;
        int         ocol;
        pixel_t     oldm;
        pixel_t     oldu;
        out_pixel_t res;
        w = eff_width(width_reg);
        h = eff_height(height_reg);
        if (it.cmd == CMD_FLUSH)
        begin
            // drains only once the frame is complete
            if (col_pos == 0 && row_pos == 0 && pend_cnt != 0)
            begin
                q = w * h - pend_cnt;
                qr = q / w;
                qc = q % w;
                res.px = (qr == h - 1) ? middle_row[qc] : upper_row[qc];
                res.frame_end = (pend_cnt == 1);
                expected_pixels.push_back(res);
                pend_cnt--;
            end
        end
        else
        begin
            if (col_pos == 0 && row_pos == 0)
                pend_cnt = 0;
            if (col_pos >= w || row_pos >= h)
                restart_frame();
            oldm = middle_row[col_pos];
            oldu = upper_row[col_pos];
            win_left = win_centre;
            win_centre = win_right;
            win_right = oldm;
            if (pend_cnt == w + 1)
            begin
                if (col_pos >= 1)
                begin
                    orow = row_pos - 1;
                    ocol = col_pos - 1;
                end
                else
                begin
                    orow = row_pos - 2;
                    ocol = w - 1;
                end
                if (orow >= 1 && orow <= h - 2 && ocol >= 1 && ocol <= w - 2)
                    res.px = sharpen_pixel(win_centre, win_up, win_down, win_left, win_right);
                else
                    res.px = win_centre;
                res.frame_end = (orow == h - 1 && ocol == w - 1);
                expected_pixels.push_back(res);
            end
            else
                pend_cnt++;
            win_up = oldu;
            win_down = it.px;
            upper_row[col_pos] = oldm;
            middle_row[col_pos] = it.px;
            col_pos++;
            if (col_pos >= w)
            begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= h)
                    row_pos = 0;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [CHAN_W-1:0] want_v,
            input logic [CHAN_W-1:0] got_v);
        if (got_v !== want_v)
        begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
                $display("%0t ns: %s expected %0d actual %0d", $time, name, want_v, got_v);
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_ready)
        begin
            if (video_items.size() != 0 && (steady || $urandom_range(0, 99) >= 8))
            begin
                next_item = video_items.pop_front();
                in_valid <= 1'b1;
                command  <= next_item.cmd;
                red_in   <= next_item.px.red;
                green_in <= next_item.px.green;
                blue_in  <= next_item.px.blue;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (stall_served != stall_asked)
        begin
            out_ready <= 1'b0;
            hold_left <= LONG_HOLD;
            stall_served <= stall_asked;
        end
        else
            out_ready <= steady || ($urandom_range(0, 99) >= 8);
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_checked++;
                if (expected_pixels.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_CAP)
                        $display("%0t ns: result with none expected, actual %h %h %h end %b",
                                 $time, red_out, green_out, blue_out, frame_end);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    check_field("blue_out", want.px.blue, blue_out);
                    check_field("green_out", want.px.green, green_out);
                    check_field("red_out", want.px.red, red_out);
                    check_field("frame_end", {7'd0, want.frame_end}, {7'd0, frame_end});
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                reg_writes++;
                apply_reg_write(cfg_index, cfg_data);
            end
            if (in_valid && in_ready)
            begin
                seen_item.cmd = command;
                seen_item.px = {red_in, green_in, blue_in};
                if (command == CMD_FLUSH)
                    flushes_in++;
                else
                    pixels_in++;
                predict_filter_out(seen_item);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t ns: no transaction for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, expected_pixels.size());
            $display("Simulation FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic push_item(input logic cmd, input pixel_t px);
        stream_item_t it;
        it.cmd = cmd;
        it.px = px;
        video_items.push_back(it);
    endtask

    task automatic push_pixels(input int n, input fill_t fill);
        pixel_t p;
        repeat (n)
        begin
            case (fill)
                FILL_EXTREME:
                begin
                    p.red   = $urandom_range(0, 1) ? PIX_MAX : '0;
                    p.green = $urandom_range(0, 1) ? PIX_MAX : '0;
                    p.blue  = $urandom_range(0, 1) ? PIX_MAX : '0;
                end
                FILL_WHITE: p = {NUM_CHAN{PIX_MAX}};
                FILL_BLACK: p = '0;
                default:    p = pixel_t'($urandom());
            endcase
            push_item(CMD_PIXEL, p);
        end
    endtask

    task automatic push_flushes(input int n);
        repeat (n)
            push_item(CMD_FLUSH, pixel_t'($urandom()));
    endtask

    // nothing queued, nothing offered, nothing owed, with no break in the quiet count
    task automatic wait_quiet();
        int quiet;
        quiet = 0;
        while (quiet < QUIET_CYCLES)
        begin
            @(posedge clk);
            if (video_items.size() == 0 && !in_valid && expected_pixels.size() == 0)
                quiet++;
            else
                quiet = 0;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
            input logic [CFG_DATA_W-1:0] data);
        wait_quiet();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int    gen_w;
        int    gen_h;
        int    wv;
        int    hv;
        int    wt;
        int    frames;
        int    kind;
        int    n;
        int    drain;
        int    random_done;
        fill_t fill;

        for (int i = 0; i < MAX_W; i++)
        begin
            upper_row[i] = '0;
            middle_row[i] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset geometry: the first pixels of the first row come back unchanged
        push_pixels(eff_width(RST_FRAME_WIDTH) + 9, FILL_RANDOM);

        // directed 3x3 frames, strongest positive weight then most negative
        write_reg(CFG_CENTER_WEIGHT, 12'hF7F);
        write_reg(CFG_FRAME_WIDTH, 12'd3);
        write_reg(CFG_FRAME_HEIGHT, 12'd3);
        push_pixels(1, FILL_WHITE);
        push_pixels(1, FILL_BLACK);
        push_pixels(1, FILL_WHITE);
        push_pixels(1, FILL_BLACK);
        push_flushes(1);
        push_item(CMD_PIXEL, pixel_t'{PIX_MAX, 8'd1, 8'd0});
        push_pixels(1, FILL_BLACK);
        push_pixels(3, FILL_WHITE);
        push_flushes(5);
        write_reg(CFG_CENTER_WEIGHT, 12'h080);
        push_pixels(9, FILL_WHITE);
        push_flushes(4);

        // wide rows, height below range; sender pause mid-frame, then a long receiver hold
        write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(WIDE_COLS));
        write_reg(CFG_FRAME_HEIGHT, 12'd0);
        write_reg(CFG_CENTER_WEIGHT, 12'd3);
        push_pixels(WIDE_COLS + 10, FILL_RANDOM);
        wait_quiet();
        stall_asked <= stall_asked + 1;
        push_pixels(WIDE_COLS * 2 - 10, FILL_RANDOM);
        push_flushes(WIDE_COLS + 1);

        // tall frame on narrowest rows, no idling on either side
        write_reg(CFG_FRAME_WIDTH, 12'd1);
        write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(TALL_ROWS));
        steady <= 1'b1;
        push_pixels(3 * TALL_ROWS, FILL_EXTREME);
        push_flushes(4);
        wait_quiet();
        steady <= 1'b0;

        gen_w = 3;
        gen_h = TALL_ROWS;
        random_done = 0;
        while (random_done < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                wt = $urandom_range(0, 16) - 8;
                write_reg(CFG_CENTER_WEIGHT,
                          CFG_DATA_W'(($urandom_range(0, 15) << 8) | (wt & 255)));
            end
            if ($urandom_range(0, 3) != 0 || gen_h > 8)
            begin
                wv = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
                hv = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
                write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(wv));
                write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(hv));
                gen_w = eff_width(DIM_W'(wv));
                gen_h = eff_height(DIM_W'(hv));
            end
            if ($urandom_range(0, 1) == 0)
                write_reg(CFG_CENTER_WEIGHT, CFG_DATA_W'($urandom_range(0, 4095)));
            frames = $urandom_range(1, 3);
            repeat (frames)
            begin
                kind = $urandom_range(0, 9);
                fill = ($urandom_range(0, 4) == 0) ? FILL_EXTREME : FILL_RANDOM;
                if (kind <= 6)
                begin
                    push_pixels(gen_w * gen_h, fill);
                    drain = $urandom_range(0, 3);
                    n = (drain == 0) ? $urandom_range(0, gen_w) : gen_w + 1;
                    push_flushes(n);
                    // flushes past the end of the drain are dropped
                    if (drain == 1)
                        push_flushes($urandom_range(1, 2));
                    random_done += gen_w * gen_h + n;
                end
                else if (kind == 7)
                begin
                    // broken frame with stray flushes
                    n = $urandom_range(1, gen_w * gen_h - 1);
                    repeat (n)
                    begin
                        push_pixels(1, fill);
                        if ($urandom_range(0, 19) == 0)
                            push_flushes(1);
                    end
                    random_done += n;
                end
                else
                begin
                    repeat ($urandom_range(2, 20))
                        push_item(1'($urandom_range(0, 1)), pixel_t'($urandom()));
                end
            end
        end

        wait_quiet();
        $display("Covered %0d pixel and %0d flush transactions, %0d results, %0d reg writes",
                 pixels_in, flushes_in, results_checked, reg_writes);
        $display("Geometry from 3x3 up to 640 wide and %0d tall, weights -128..127, %0d mismatches",
                 TALL_ROWS, mismatches);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
